>>> hw/rtl/dtv_pkg.sv
package dtv_pkg;

    localparam int unsigned DIGITS    = 14;
    localparam int unsigned COUNT_MAX = 15;
    localparam int unsigned VAL_W     = 47;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [6:0] MONTH_FEB  = 7'd2;
    localparam logic [6:0] MONTH_DEC  = 7'd12;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;

    typedef logic [3:0]              t_digit;
    typedef logic [DIGITS-1:0][3:0]  t_digits;
    typedef logic [6:0]              t_num2;
    typedef logic [3:0]              t_count;
    typedef logic [VAL_W-1:0]        t_value;

    // two decimal digits as a binary number
    function automatic t_num2 two_dig(input t_digit hi, input t_digit lo);
        return t_num2'(hi) * 7'd10 + t_num2'(lo);
    endfunction

    // days in month, February without leap day; 0 for codes that name no month
    function automatic logic [4:0] month_days(input t_num2 month);
        logic [4:0] days;
        case (month)
            7'd1:    days = 5'd31;
            7'd2:    days = 5'd28;
            7'd3:    days = 5'd31;
            7'd4:    days = 5'd30;
            7'd5:    days = 5'd31;
            7'd6:    days = 5'd30;
            7'd7:    days = 5'd31;
            7'd8:    days = 5'd31;
            7'd9:    days = 5'd30;
            7'd10:   days = 5'd31;
            7'd11:   days = 5'd30;
            7'd12:   days = 5'd31;
            default: days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

>>> hw/rtl/dtv_cell.sv
module dtv_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_clear,
    input  dtv_pkg::t_digit i_digit,
    output dtv_pkg::t_digit o_digit,
    output dtv_pkg::t_digit o_next
);
    import dtv_pkg::*;

    t_digit r_digit;
    t_digit n_digit;

    assign n_digit = i_shift ? i_digit : r_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;
    assign o_next  = n_digit;

endmodule

>>> hw/rtl/dtv_check.sv
module dtv_check (
    input  dtv_pkg::t_digits i_digits,
    input  logic             i_fmt_ok,
    output logic             o_ok
);
    import dtv_pkg::*;

    t_num2      cent;
    t_num2      yr;
    t_num2      month;
    t_num2      day;
    t_num2      hour;
    t_num2      minute;
    t_num2      second;
    logic       leap;
    logic [5:0] limit;

    always_comb begin
        cent   = two_dig(i_digits[0], i_digits[1]);
        yr     = two_dig(i_digits[2], i_digits[3]);
        month  = two_dig(i_digits[4], i_digits[5]);
        day    = two_dig(i_digits[6], i_digits[7]);
        hour   = two_dig(i_digits[8], i_digits[9]);
        minute = two_dig(i_digits[10], i_digits[11]);
        second = two_dig(i_digits[12], i_digits[13]);
        // century years are leap only when the century count divides by four
        leap   = (yr == '0) ? (cent[1:0] == 2'b00) : (yr[1:0] == 2'b00);
        limit  = {1'b0, month_days(month)} + {5'b0, (month == MONTH_FEB) && leap};
        o_ok   = i_fmt_ok
              && (i_digits[0] != '0)
              && (month != '0) && (month <= MONTH_DEC)
              && (day != '0) && (day <= {1'b0, limit})
              && (hour <= HOUR_MAX) && (minute <= MINSEC_MAX) && (second <= MINSEC_MAX);
    end

endmodule

>>> hw/rtl/datetime_string_validator.sv
// Datetime text validator.
// Input channel: one character per item (i_char_code) with i_last_char on the
// final character, handshake i_valid / o_stall. Separators ':', '-' and space
// are dropped; any other non-digit marks the text bad.
// Output channel: one result per text, o_is_valid and o_packed_value
// (YYYYMMDDhhmmss as binary, 0 when invalid), handshake o_valid / i_stall.
// Throughput: one character per cycle while o_stall is low, texts back to back with no gap.
// Path: a snapshot stage holds the finished digits after the edge that takes
// the final character; the check and output register follow. The digits
// shift through a row of 14 cells; the binary value is built one
// multiply-by-ten add per accepted digit.
// Reset clears the count, error flag, value and all stages; no result is
// pending afterward. When the receiver stalls, the output holds; the snapshot
// stage fills next, and only then is o_stall raised toward the sender.
module datetime_string_validator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_last_char,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_is_valid,
    output logic [dtv_pkg::VAL_W-1:0]   o_packed_value
);
    import dtv_pkg::*;

    logic    accept;
    logic    is_dig;
    logic    is_sep;
    t_digit  digit;
    logic    shift;
    logic    clear;

    t_count  r_count;
    t_count  n_count;
    logic    r_bad;
    logic    n_bad;
    t_value  r_acc;
    t_value  n_acc;

    t_digits cur_digits;
    t_digits next_digits;

    logic    r_a_vld;
    t_digits r_a_digits;
    t_value  r_a_acc;
    logic    r_a_fmt;
    logic    a_ok;

    logic    r_o_vld;
    logic    r_o_ok;
    t_value  r_o_val;

    logic    out_free;
    logic    a_adv;
    logic    a_free;

    assign out_free = !r_o_vld || !i_stall;
    assign a_adv    = r_a_vld && out_free;
    assign a_free   = !r_a_vld || out_free;
    assign o_stall  = !a_free;
    assign accept   = i_valid && a_free;

    assign is_dig = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_sep = (i_char_code == CH_COLON) || (i_char_code == CH_DASH)
                 || (i_char_code == CH_SPACE);
    assign digit  = t_digit'(i_char_code - CH_ZERO);
    assign shift  = accept && is_dig && (r_count < t_count'(DIGITS));
    assign clear  = accept && i_last_char;

    always_comb begin
        n_count = r_count;
        n_bad   = r_bad;
        n_acc   = r_acc;
        if (accept) begin
            if (is_dig && (r_count != t_count'(COUNT_MAX))) begin
                n_count = r_count + 4'd1;
            end
            if (!is_dig && !is_sep) begin
                n_bad = 1'b1;
            end
            if (shift) begin
                n_acc = {r_acc[VAL_W-4:0], 3'b000} + {r_acc[VAL_W-2:0], 1'b0}
                      + t_value'(digit);
            end
        end
    end

    // digits enter at the top cell and move down; the first digit ends in cell 0
    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        t_digit cell_in;
        if (g == DIGITS - 1) begin : g_top
            assign cell_in = digit;
        end else begin : g_mid
            assign cell_in = cur_digits[g+1];
        end
        dtv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_digit (cell_in),
            .o_digit (cur_digits[g]),
            .o_next  (next_digits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_count <= '0;
            r_bad   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_count <= n_count;
            r_bad   <= n_bad;
            r_acc   <= n_acc;
        end
    end

    // snapshot stage: hold the finished text for the check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (clear) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_a_digits <= next_digits;
            r_a_acc    <= n_acc;
            r_a_fmt    <= !n_bad && (n_count == t_count'(DIGITS));
        end
    end

    dtv_check u_check (
        .i_digits (r_a_digits),
        .i_fmt_ok (r_a_fmt),
        .o_ok     (a_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_ok  <= a_ok;
            r_o_val <= a_ok ? r_a_acc : '0;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_is_valid     = r_o_ok;
    assign o_packed_value = r_o_val;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_valid) |-> (o_packed_value == '0))
        else $error("invalid result carries a nonzero value");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_vld && r_o_vld))
        else $error("sender stalled while a stage is free");
    a_fmt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (clear && !is_dig && !is_sep) |=> (r_a_vld && !r_a_fmt))
        else $error("bad character not flagged in snapshot");
`endif

endmodule

>>> verif/datetime_string_validator_tb.sv
`timescale 1ns / 100ps

module datetime_string_validator_tb;
    import dtv_pkg::*;

    typedef struct packed {
        logic   ok;
        t_value value;
    } t_verdict;

    class datetime_checker;
        t_count      digit_cnt;
        bit          bad_seen;
        t_digit      digits [DIGITS];
        t_value      accum;
        t_verdict    pending_verdicts [$];
        int unsigned errors;

        function new();
            errors = 0;
            restart_text();
        endfunction

        function void restart_text();
            digit_cnt = '0;
            bad_seen  = 1'b0;
            accum     = '0;
            foreach (digits[i]) digits[i] = '0;
        endfunction

        function int unsigned num2(int unsigned pos);
            return digits[pos] * 10 + digits[pos + 1];
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        endfunction

        // calendar and clock range check on the 14 stored digits
        function bit fields_in_range();
            int unsigned year;
            int unsigned month;
            int unsigned day;
            int unsigned lim;
            year  = digits[0] * 1000 + digits[1] * 100 + digits[2] * 10 + digits[3];
            month = num2(4);
            day   = num2(6);
            if (year < 1000 || year > 9999 || month == 0 || month > MONTH_DEC || day == 0)
                return 1'b0;
            if (month == MONTH_FEB)
                lim = leap_year(year) ? 29 : 28;
            else if (month == 4 || month == 6 || month == 9 || month == 11)
                lim = 30;
            else
                lim = 31;
            return day <= lim && num2(8) <= HOUR_MAX && num2(10) <= MINSEC_MAX
                && num2(12) <= MINSEC_MAX;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            t_verdict v;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (digit_cnt < DIGITS) begin
                    digits[digit_cnt] = t_digit'(c - CH_ZERO);
                    accum = accum * 10 + (c - CH_ZERO);
                end
                if (digit_cnt < COUNT_MAX)
                    digit_cnt++;
            end else if (c != CH_COLON && c != CH_DASH && c != CH_SPACE) begin
                bad_seen = 1'b1;
            end
            if (last) begin
                v.ok    = !bad_seen && digit_cnt == DIGITS && fields_in_range();
                v.value = v.ok ? accum : '0;
                pending_verdicts.push_back(v);
                restart_text();
            end
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(logic ok, t_value value);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("unexpected result is_valid=%0b value=%0d", ok, value));
                return;
            end
            want = pending_verdicts.pop_front();
            if (ok !== want.ok)
                report($sformatf("is_valid got %0b want %0b", ok, want.ok));
            if (value !== want.value)
                report($sformatf("packed_value got %0d want %0d", value, want.value));
        endtask

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_CHARS    = 410;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_valid     = 1'b0;
    logic         o_stall;
    logic [7:0]   i_char_code = '0;
    logic         i_last_char = 1'b0;
    logic         o_valid;
    logic         i_stall     = 1'b0;
    logic         o_is_valid;
    t_value       o_packed_value;

    datetime_checker checker_h = new();

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned chars_sent  = 0;
    int unsigned idle_cycles = 0;

    logic [7:0] text_q [$];
    t_digit     digit_q [$];

    datetime_string_validator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_valid     (o_is_valid),
        .o_packed_value (o_packed_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // sample both channels on pre-edge values, then drive the next stall
    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            checker_h.note_char(i_char_code, i_last_char);
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            checker_h.check_result(o_is_valid, o_packed_value);
            moved = 1'b1;
        end
        i_stall <= ($urandom_range(1, 100) <= stall_pct);
        if (moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_char(logic [7:0] c, logic last);
        while ($urandom_range(1, 100) <= idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            push_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic load_string(string s);
        text_q.delete();
        foreach (s[i]) text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 2))
            0:       return CH_COLON;
            1:       return CH_DASH;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON || c == CH_DASH
                   || c == CH_SPACE);
        return c;
    endfunction

    task automatic push_num(int unsigned n, int unsigned ndig);
        int unsigned scale;
        scale = 1;
        repeat (ndig - 1) scale *= 10;
        repeat (ndig) begin
            digit_q.push_back(t_digit'((n / scale) % 10));
            scale /= 10;
        end
    endtask

    // mostly well-formed datetimes near the calendar edges, some mangled, some noise
    task automatic build_text();
        int unsigned year;
        int unsigned style;
        text_q.delete();
        digit_q.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 20)) begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(8'($urandom_range(0, 255)));
                    1:       text_q.push_back(bad_char());
                    2:       text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: text_q.push_back(sep_char());
                endcase
            end
            return;
        end
        case ($urandom_range(0, 7))
            0: year = $urandom_range(0, 1100);
            1: begin
                case ($urandom_range(0, 5))
                    0:       year = 1000;
                    1:       year = 9999;
                    2:       year = 1900;
                    3:       year = 2000;
                    4:       year = 2024;
                    default: year = 2100;
                endcase
            end
            default: year = $urandom_range(1000, 9999);
        endcase
        push_num(year, 4);
        case ($urandom_range(0, 9))
            0:       push_num($urandom_range(0, 99), 2);
            1, 2:    push_num(MONTH_FEB, 2);
            default: push_num($urandom_range(1, 12), 2);
        endcase
        case ($urandom_range(0, 9))
            0:       push_num($urandom_range(0, 99), 2);
            1, 2, 3: push_num($urandom_range(28, 31), 2);
            default: push_num($urandom_range(1, 31), 2);
        endcase
        push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 24), 2);
        repeat (2)
            push_num(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                 : $urandom_range(0, 60), 2);
        case ($urandom_range(0, 19))
            0, 1: digit_q.delete($urandom_range(0, digit_q.size() - 1));
            2, 3: begin
                repeat ($urandom_range(1, 6))
                    digit_q.insert($urandom_range(0, digit_q.size()),
                                   t_digit'($urandom_range(0, 9)));
            end
            default: ;
        endcase
        style = $urandom_range(0, 2);
        foreach (digit_q[i]) begin
            if (style == 1 && (i == 4 || i == 6))
                text_q.push_back(CH_DASH);
            if (style == 1 && i == 8)
                text_q.push_back(CH_SPACE);
            if (style == 1 && (i == 10 || i == 12))
                text_q.push_back(CH_COLON);
            if (style == 2 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) text_q.push_back(sep_char());
            text_q.push_back(CH_ZERO + 8'(digit_q[i]));
        end
        // in style 2, sometimes a separator as the final character
        if (style == 2 && $urandom_range(0, 3) == 0)
            text_q.push_back(sep_char());
        if ($urandom_range(0, 9) == 0)
            text_q.insert($urandom_range(0, text_q.size()), bad_char());
    endtask

    initial begin
        int unsigned target;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        text_q = '{8'h00};
        send_text();
        text_q = '{8'hFF};
        send_text();
        text_q = '{CH_SPACE, CH_DASH, CH_COLON};
        send_text();
        load_string("99991231235959-");
        send_text();
        load_string("5");
        send_text();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) begin
                build_text();
                send_text();
            end
            if (phase == 1) begin
                // hold off until every result has drained
                i_valid <= 1'b0;
                while (checker_h.pending() != 0) @(posedge i_clk);
            end
        end

        i_valid   <= 1'b0;
        stall_pct = 0;
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (checker_h.pending() != 0)
            checker_h.report($sformatf("%0d results never arrived", checker_h.pending()));

        if (checker_h.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dtv_pkg.sv
hw/rtl/dtv_cell.sv
hw/rtl/dtv_check.sv
hw/rtl/datetime_string_validator.sv
verif/datetime_string_validator_tb.sv
